/* rtl/modular_ring_alu_top_assert.svh */
// Assertion macros shared by the checker.
`ifndef MODULAR_RING_ALU_TOP_ASSERT_SVH
`define MODULAR_RING_ALU_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MRA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* rtl/mra_pkg.sv */
package mra_pkg;
	localparam int W = 32;
	localparam logic [W-1:0] MOD_RESET = 32'd1000000007;
	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_DIV = 3'd3;
	localparam logic [2:0] MODE_INV = 3'd4;

	// Shared unit operation codes.
	typedef enum logic [1:0] {
		OP_MULMOD = 2'd0,
		OP_DIVREM = 2'd1
	} op_t;

	typedef struct packed {
		logic   start;
		op_t    op;
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W-1:0] m;
	} unit_req_t;

	typedef struct packed {
		logic         done;
		logic [W-1:0] q;
		logic [W-1:0] r;
	} unit_rsp_t;
endpackage

/* rtl/mra_unit.sv */
// Shared bit-serial unit: modular multiply (a*b mod m by double-and-add)
// or division (a / b, remainder), one bit per cycle.
module mra_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  mra_pkg::unit_req_t  req,
	output mra_pkg::unit_rsp_t  rsp
);
	logic               busy_q;
	logic               done_q;
	logic [5:0]         cnt_q;
	mra_pkg::op_t       op_q;
	logic [mra_pkg::W-1:0] a_q, b_q, m_q, acc_q, quo_q;
	logic [mra_pkg::W:0]   dbl, s2, rem2, t;
	logic [mra_pkg::W-1:0] acc1, acc2;

	always_comb begin
		// acc = 2*acc mod m, then conditionally + a mod m.
		dbl = {acc_q, 1'b0};
		acc1 = (dbl >= {1'b0, m_q}) ? mra_pkg::W'(dbl - {1'b0, m_q}) : dbl[mra_pkg::W-1:0];
		s2 = {1'b0, acc1} + {1'b0, a_q};
		acc2 = b_q[mra_pkg::W-1] ? ((s2 >= {1'b0, m_q}) ?
			mra_pkg::W'(s2 - {1'b0, m_q}) : s2[mra_pkg::W-1:0]) : acc1;
		// Restoring division step: shift next dividend bit into remainder.
		rem2 = {acc_q, a_q[mra_pkg::W-1]};
		t = rem2 - {1'b0, b_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				op_q <= req.op;
				a_q <= req.a;
				b_q <= req.b;
				m_q <= req.m;
				acc_q <= '0;
				quo_q <= '0;
			end else if (busy_q) begin
				if (op_q == mra_pkg::OP_MULMOD) begin
					acc_q <= acc2;
					b_q <= {b_q[mra_pkg::W-2:0], 1'b0};
				end else begin
					a_q <= {a_q[mra_pkg::W-2:0], 1'b0};
					if (!t[mra_pkg::W]) begin
						acc_q <= t[mra_pkg::W-1:0];
						quo_q <= {quo_q[mra_pkg::W-2:0], 1'b1};
					end else begin
						acc_q <= rem2[mra_pkg::W-1:0];
						quo_q <= {quo_q[mra_pkg::W-2:0], 1'b0};
					end
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(mra_pkg::W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Results are valid together with done and hold until the next start.
	always_comb begin
		rsp.done = done_q;
		rsp.q = (op_q == mra_pkg::OP_MULMOD) ? acc_q : quo_q;
		rsp.r = acc_q;
	end
endmodule

/* rtl/mra_seq.sv */
// Sequencer: reduction, add/sub, Euclid loop and final multiply;
// all but add/sub drive the one shared unit.
module mra_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [2:0]            mode,
	input  logic [mra_pkg::W-1:0] opa,
	input  logic [mra_pkg::W-1:0] opb,
	input  logic [mra_pkg::W-1:0] modv,
	output logic                  busy,
	output logic                  fin,
	output logic [mra_pkg::W-1:0] res,
	output mra_pkg::unit_req_t    req,
	input  mra_pkg::unit_rsp_t    rsp
);
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_REDA  = 9'b000000010,
		S_REDB  = 9'b000000100,
		S_DISP  = 9'b000001000,
		S_EDIV  = 9'b000010000,
		S_EQM   = 9'b000100000,
		S_EMUL  = 9'b001000000,
		S_FMUL  = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [2:0] mode_q;
	logic [mra_pkg::W-1:0] m_q, a_q, b_q, x_q, y_q, u_q, v_q, r_q, res_q;
	logic wait_q;
	logic [mra_pkg::W:0] sum;
	logic [mra_pkg::W-1:0] nv;

	assign busy = (state_q != S_IDLE);
	assign res = res_q;
	always_comb begin
		sum = {1'b0, a_q} + {1'b0, b_q};
		nv = (u_q >= rsp.q) ? (u_q - rsp.q) : (u_q + (m_q - rsp.q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q <= 1'b0;
			fin <= 1'b0;
			req.start <= 1'b0;
		end else begin
			fin <= 1'b0;
			req.start <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (go) begin
						mode_q <= mode;
						m_q <= modv;
						a_q <= opa;
						b_q <= opb;
						if (modv == '0) begin
							res_q <= '0;
							state_q <= S_DONE;
						end else begin
							req <= '{1'b1, mra_pkg::OP_DIVREM, opa, modv, modv};
							state_q <= S_REDA;
						end
					end
				end
				S_REDA: if (rsp.done) begin
					a_q <= rsp.r;
					req <= '{1'b1, mra_pkg::OP_DIVREM, b_q, m_q, m_q};
					state_q <= S_REDB;
				end
				S_REDB: if (rsp.done) begin
					b_q <= rsp.r;
					state_q <= S_DISP;
				end
				S_DISP: begin
					case (mode_q)
						mra_pkg::MODE_ADD: begin
							res_q <= (sum >= {1'b0, m_q}) ?
								mra_pkg::W'(sum - {1'b0, m_q}) : sum[mra_pkg::W-1:0];
							state_q <= S_DONE;
						end
						mra_pkg::MODE_SUB: begin
							res_q <= (a_q >= b_q) ? (a_q - b_q) : (a_q + (m_q - b_q));
							state_q <= S_DONE;
						end
						mra_pkg::MODE_MUL: begin
							req <= '{1'b1, mra_pkg::OP_MULMOD, a_q, b_q, m_q};
							state_q <= S_FMUL;
						end
						mra_pkg::MODE_DIV, mra_pkg::MODE_INV: begin
							x_q <= (mode_q == mra_pkg::MODE_DIV) ? b_q : a_q;
							y_q <= m_q;
							u_q <= (m_q == mra_pkg::W'(1)) ? '0 : mra_pkg::W'(1);
							v_q <= '0;
							wait_q <= 1'b0;
							state_q <= S_EDIV;
						end
						default: begin
							res_q <= '0;
							state_q <= S_DONE;
						end
					endcase
				end
				S_EDIV: begin
					if (!wait_q) begin
						if (y_q == '0) begin
							if (mode_q == mra_pkg::MODE_DIV) begin
								req <= '{1'b1, mra_pkg::OP_MULMOD, a_q, u_q, m_q};
								state_q <= S_FMUL;
							end else begin
								res_q <= u_q;
								state_q <= S_DONE;
							end
						end else begin
							req <= '{1'b1, mra_pkg::OP_DIVREM, x_q, y_q, m_q};
							wait_q <= 1'b1;
						end
					end else if (rsp.done) begin
						wait_q <= 1'b0;
						r_q <= rsp.r;
						req <= '{1'b1, mra_pkg::OP_DIVREM, rsp.q, m_q, m_q};
						state_q <= S_EQM;
					end
				end
				S_EQM: if (rsp.done) begin
					req <= '{1'b1, mra_pkg::OP_MULMOD, rsp.r, v_q, m_q};
					state_q <= S_EMUL;
				end
				S_EMUL: if (rsp.done) begin
					x_q <= y_q;
					y_q <= r_q;
					u_q <= v_q;
					v_q <= nv;
					state_q <= S_EDIV;
				end
				S_FMUL: if (rsp.done) begin
					res_q <= rsp.q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					fin <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/modular_ring_alu_top.sv */
// Modular ring ALU: add, subtract, multiply, divide and inverse modulo a
// configured modulus.
// Input channel s_axis_*: one item per command. tdata holds, from the lowest
// bit up, first_operand [31:0] and second_operand [63:32]; tuser holds mode.
// Output channel m_axis_*: tdata holds result [31:0], one item per command.
// The modulus is written through cfg_we/cfg_wdata, by the user only while the
// block is idle (the block itself does not enforce this); it resets to 1000000007.
// Reductions, multiplies and Euclid steps run on one shared bit-serial unit
// that does one bit of a modular multiply or of a division per cycle.
// Unless the modulus is zero (result zero), both operands are first reduced
// on the unit. Add and subtract then finish in the sequencer, multiply with
// one unit multiply. Inverse needs three unit operations per Euclid
// iteration; divide adds one more multiply.
// The block takes one item at a time: s_axis_tready is low from acceptance
// until the result has been taken. A result sits in an output register while
// the receiver stalls. Reset clears the sequencer and the output valid.
module modular_ring_alu_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // first_operand, second_operand
	input  logic [2:0]  s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // result
);
	logic [mra_pkg::W-1:0] mod_q;
	logic busy, fin, out_v_q;
	logic [mra_pkg::W-1:0] res;
	mra_pkg::unit_req_t req;
	mra_pkg::unit_rsp_t rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mod_q <= mra_pkg::MOD_RESET;
		else if (cfg_we) mod_q <= cfg_wdata;
	end

	// Ready only when the sequencer and the output register are both empty.
	// In the cycle the result is handed over the sequencer is already idle,
	// so that cycle is excluded as well.
	assign s_axis_tready = !busy && !out_v_q && !fin;

	mra_seq u_seq (
		.clk, .arst_n,
		.go(s_axis_tvalid && s_axis_tready),
		.mode(s_axis_tuser),
		.opa(s_axis_tdata[31:0]),
		.opb(s_axis_tdata[63:32]),
		.modv(mod_q),
		.busy, .fin, .res, .req, .rsp
	);

	mra_unit u_unit (.clk, .arst_n, .req, .rsp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (fin) out_v_q <= 1'b1;
		else if (m_axis_tready) out_v_q <= 1'b0;
	end
	always_ff @(posedge clk) if (fin) m_axis_tdata <= res;
	assign m_axis_tvalid = out_v_q;
endmodule

/* rtl/modular_ring_alu_checker.sv */
`include "modular_ring_alu_top_assert.svh"
module modular_ring_alu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);
	`MRA_ASSERT_IMPL(a_no_accept_while_out, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	`MRA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`MRA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind modular_ring_alu_top modular_ring_alu_checker u_chk (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

/* verif/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Clock and reset. Reset is asserted once, at the start of the run.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #10 clk = ~clk;

	// Block inputs, all driven to known values from time zero.
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;   // first_operand, second_operand
	logic [2:0]  s_axis_tuser = '0;   // mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // result

	modular_ring_alu_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Our own copy of the modulus register and the queue of residues that
	// the block still owes us, oldest first.
	logic [31:0] ring_modulus = mra_pkg::MOD_RESET;
	logic [31:0] pending_residues[$];
	int          error_count = 0;
	longint      cycle_count = 0;

	// Generous limit: covers the slowest items, inverse and divide, plus sender
	// and receiver gaps, for 1238 items.
	localparam longint CYCLE_LIMIT = 64'd40000000;

	function automatic logic [63:0] ring_add(logic [63:0] a, logic [63:0] b,
			logic [63:0] m);
		logic [63:0] s;
		s = a + b;
		if (s < a || s >= m) s = s - m;
		return s;
	endfunction

	function automatic logic [63:0] ring_sub(logic [63:0] a, logic [63:0] b,
			logic [63:0] m);
		return (a >= b) ? (a - b) : (a + (m - b));
	endfunction

	function automatic logic [63:0] ring_mul(logic [63:0] a, logic [63:0] b,
			logic [63:0] m);
		logic [63:0] acc;
		acc = 0;
		for (int i = 63; i >= 0; i--) begin
			acc = ring_add(acc, acc, m);
			if (b[i]) acc = ring_add(acc, a, m);
		end
		return acc;
	endfunction

	// Extended Euclid on (a, m) with the coefficient kept reduced mod m.
	// For a value that shares a factor with m this still returns whatever
	// coefficient the iteration ends with.
	function automatic logic [63:0] ring_inverse(logic [63:0] a, logic [63:0] m);
		logic [63:0] x, y, u, v, q, r, nv;
		x = a;
		y = m;
		u = 64'd1 % m;
		v = 0;
		while (y > 0) begin
			q = x / y;
			r = x % y;
			nv = ring_sub(u, ring_mul(q % m, v, m), m);
			x = y;
			y = r;
			u = v;
			v = nv;
		end
		return u;
	endfunction

	function automatic logic [31:0] ring_result(logic [2:0] mode, logic [31:0] fa,
			logic [31:0] fb, logic [31:0] modv);
		logic [63:0] m, a, b, r;
		m = modv;
		r = 0;
		if (m != 0) begin
			a = fa % m;
			b = fb % m;
			case (mode)
				mra_pkg::MODE_ADD: r = ring_add(a, b, m);
				mra_pkg::MODE_SUB: r = ring_sub(a, b, m);
				mra_pkg::MODE_MUL: r = ring_mul(a, b, m);
				mra_pkg::MODE_DIV: r = ring_mul(a, ring_inverse(b, m), m);
				mra_pkg::MODE_INV: r = ring_inverse(a, m);
				default: r = 0;
			endcase
		end
		return r[31:0];
	endfunction

	// Sends one item after a random gap and records its expected residue.
	// Valid stays high after acceptance; the caller either presents the next
	// item at that same edge or drops valid there.
	task automatic send_item(logic [2:0] mode, logic [31:0] fa, logic [31:0] fb);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pending_residues.push_back(ring_result(mode, fa, fb, ring_modulus));
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {fb, fa};
		s_axis_tuser <= mode;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Waits until every expected residue has arrived, then lets the block
	// settle before the modulus changes.
	task automatic write_modulus(logic [31:0] value);
		s_axis_tvalid <= 1'b0;
		while (pending_residues.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		ring_modulus = value;
	endtask

	// Receiver: stalls at random before each item it takes.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 4);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	// Checker: compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_residues.size() == 0) begin
				$display("%0t: unexpected result %0d", $time, m_axis_tdata);
				error_count <= error_count + 1;
			end else begin
				if (pending_residues[0] !== m_axis_tdata) begin
					$display("%0t: result mismatch expected %0d actual %0d",
						$time, pending_residues[0], m_axis_tdata);
					error_count <= error_count + 1;
				end
				void'(pending_residues.pop_front());
			end
		end
	end

	// Timeout watchdog.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("modular_ring_alu_top verification failed");
		$finish;
	end

	// Edge values of the operands, every mode including the unused codes,
	// zero inverse and a non-coprime value under the reset modulus.
	task automatic test_directed_reset_modulus();
		send_item(mra_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(mra_pkg::MODE_ADD, 32'd0, 32'd0);
		send_item(mra_pkg::MODE_SUB, 32'd0, 32'hFFFF_FFFF);
		send_item(mra_pkg::MODE_SUB, 32'd1000000006, 32'd1);
		send_item(mra_pkg::MODE_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(mra_pkg::MODE_MUL, 32'd1000000006, 32'd1000000006);
		send_item(mra_pkg::MODE_DIV, 32'd12345, 32'd678);
		send_item(mra_pkg::MODE_DIV, 32'hFFFF_FFFF, 32'd0);
		send_item(mra_pkg::MODE_INV, 32'd0, 32'hFFFF_FFFF);
		send_item(mra_pkg::MODE_INV, 32'd1000000007, 32'd0);
		send_item(mra_pkg::MODE_INV, 32'd2, 32'd0);
		send_item(3'd5, 32'd7, 32'd9);
		send_item(3'd6, 32'hFFFF_FFFF, 32'd1);
		send_item(3'd7, 32'd1, 32'hFFFF_FFFF);
	endtask

	// Degenerate moduli: zero and one make every result zero; the largest
	// modulus and an even one exercise wrap and non-coprime inverses.
	task automatic test_modulus_extremes();
		logic [31:0] moduli[4] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd360};
		foreach (moduli[k]) begin
			write_modulus(moduli[k]);
			send_item(mra_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
			send_item(mra_pkg::MODE_SUB, 32'd3, 32'hFFFF_FFFF);
			send_item(mra_pkg::MODE_MUL, 32'hFFFF_FFFE, 32'hFFFF_FFFD);
			send_item(mra_pkg::MODE_DIV, 32'd100, 32'd7);
			send_item(mra_pkg::MODE_INV, 32'd6, 32'd0);
			send_item(mra_pkg::MODE_INV, 32'd7, 32'd0);
		end
	endtask

	// Random items over several moduli. Operands are mostly full width, some
	// small, so that reduced values and coprime cases both occur often.
	task automatic test_random_phases();
		logic [31:0] modv, fa, fb;
		logic [2:0] mode;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: modv = $urandom();
				1: modv = $urandom_range(2, 1000);
				2: modv = 32'hFFFF_FFFB;
				default: modv = $urandom() | 32'h8000_0000;
			endcase
			write_modulus(modv);
			for (int n = 0; n < 150; n++) begin
				mode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
					: 3'($urandom_range(0, 4));
				fa = $urandom_range(0, 3) == 0 ? $urandom_range(0, 64) : $urandom();
				fb = $urandom_range(0, 3) == 0 ? $urandom_range(0, 64) : $urandom();
				send_item(mode, fa, fb);
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_reset_modulus();
		test_modulus_extremes();
		test_random_phases();
		s_axis_tvalid <= 1'b0;
		while (pending_residues.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (error_count == 0) begin
			$display("modular_ring_alu_top verification clean");
		end else begin
			$display("modular_ring_alu_top verification failed");
		end
		$finish;
	end
endmodule
